/* rtl/ecbt_pkg.sv */
// Shared types and constants of the event control block table.
// Request and response payloads, slot record, slot state and request codes.
// Used by every module of the block; depends on nothing.
package ecbt_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int EFF_W     = $clog2(NUM_SLOTS + 1);
   localparam int CNT_W     = 5;
   localparam int CB_SLOT_W = 4;
   localparam int IDX_W     = 16;

   localparam logic [31:0] OPEN_TAG = 32'hf100_0000;
   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
   localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(16);

   typedef enum logic [2:0] {
      FUNC_OPEN      = 3'd0,
      FUNC_CLOSE     = 3'd1,
      FUNC_ENABLE    = 3'd2,
      FUNC_DISABLE   = 3'd3,
      FUNC_DELIVER   = 3'd4,
      FUNC_UNDELIVER = 3'd5,
      FUNC_TEST      = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_DISABLED = 2'd1,
      ST_ENABLED  = 2'd2,
      ST_PENDING  = 2'd3
   } slot_state_type;

   localparam logic [1:0] MODE_CALLBACK    = 2'd0;
   localparam logic [1:0] MODE_NO_CALLBACK = 2'd1;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] handle;
      logic [31:0] event_class;
      logic [31:0] event_spec;
      logic [1:0]  event_mode;
      logic [31:0] handler_addr;
   } req_type;

   typedef struct packed {
      logic [31:0]          ret_value;
      logic                 index_error;
      logic                 callback_valid;
      logic [31:0]          callback_addr;
      logic [CB_SLOT_W-1:0] callback_slot;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] event_class;
      logic [31:0] event_spec;
      logic [1:0]  event_mode;
      logic [31:0] handler_addr;
   } rec_type;

   // sequencer -> slot store
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              we_state;
      logic              we_rec;
      logic [SLOT_W-1:0] waddr;
      slot_state_type    wstate;
      rec_type           wrec;
   } store_req_type;

   // slot store -> sequencer, registered, valid in the cycle after rd_en
   typedef struct packed {
      slot_state_type state;
      rec_type        rec;
   } store_rsp_type;

   // min(slot_count, NUM_SLOTS)
   function automatic logic [EFF_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
      if (32'(cnt) < NUM_SLOTS) begin
         return EFF_W'(cnt);
      end
      return EFF_W'(NUM_SLOTS);
   endfunction

endpackage

/* rtl/ecbt_store.sv */
// Slot store: state memory with per-entry valid bits, and slot record memory.
// One read port (registered) and one write port. Uses ecbt_pkg.
module ecbt_store (
   input  logic                   clock,
   input  logic                   reset,
   input  ecbt_pkg::store_req_type store_req,
   output ecbt_pkg::store_rsp_type store_rsp
);
   import ecbt_pkg::*;

   slot_state_type state_mem [NUM_SLOTS];
   rec_type        rec_mem   [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   store_rsp_type  rdata_ff;

   // entries never written read as free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store_req.we_state) begin
         valid_ff[store_req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.we_state) begin
         state_mem[store_req.waddr] <= store_req.wstate;
      end
      if (store_req.we_rec) begin
         rec_mem[store_req.waddr] <= store_req.wrec;
      end
      if (store_req.rd_en) begin
         rdata_ff.state <= valid_ff[store_req.rd_addr] ? state_mem[store_req.rd_addr]
                                                       : ST_FREE;
         rdata_ff.rec   <= rec_mem[store_req.rd_addr];
      end
   end

   assign store_rsp = rdata_ff;

endmodule

/* rtl/ecbt_seq.sv */
// Request sequencer: single-slot read-modify-write and pipelined slot scans.
// Drives the slot store and the registered response. Uses ecbt_pkg.
module ecbt_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ecbt_pkg::req_type       req_data,
   input  logic [ecbt_pkg::EFF_W-1:0] eff,
   output logic                    busy,
   output logic                    rsp_strobe,
   output ecbt_pkg::rsp_type       rsp_data,
   output ecbt_pkg::store_req_type store_req,
   input  ecbt_pkg::store_rsp_type store_rsp
);
   import ecbt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SINGLE, S_SCAN, S_FLUSH} seq_state_type;

   seq_state_type        state_ff, state_in;
   req_type              req_ff, req_in;
   logic [EFF_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 pv_ff, pv_in;
   logic [EFF_W-1:0]     pidx_ff, pidx_in;
   logic                 cb_pend_ff, cb_pend_in;
   logic [31:0]          cb_addr_ff, cb_addr_in;
   logic [CB_SLOT_W-1:0] cb_slot_ff, cb_slot_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   always_comb begin
      func_type f_new;
      func_type f_cur;
      logic     in_range;
      logic     last_slot;
      logic     match;
      store_rsp_type rd;

      f_new     = func_type'(req_data.func);
      f_cur     = func_type'(req_ff.func);
      in_range  = req_data.handle[IDX_W-1:0] < IDX_W'(eff);
      last_slot = pidx_ff == (eff - EFF_W'(1));
      rd        = store_rsp;
      match     = (rd.rec.event_class == req_ff.event_class) &&
                  (rd.rec.event_spec == req_ff.event_spec);

      state_in      = state_ff;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      pv_in         = 1'b0;
      pidx_in       = pidx_ff;
      cb_pend_in    = cb_pend_ff;
      cb_addr_in    = cb_addr_ff;
      cb_slot_in    = cb_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      store_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               cb_pend_in = 1'b0;
               case (f_new) inside
                  FUNC_OPEN, FUNC_DELIVER, FUNC_UNDELIVER: begin
                     if (eff == '0) begin
                        rsp_strobe_in    = 1'b1;
                        rsp_in.ret_value = (f_new == FUNC_OPEN) ? ALL_ONES : 32'd0;
                        rsp_in.last      = 1'b1;
                     end else begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = '0;
                        rd_idx_in         = EFF_W'(1);
                        pv_in             = 1'b1;
                        pidx_in           = '0;
                        state_in          = S_SCAN;
                     end
                  end
                  FUNC_CLOSE, FUNC_ENABLE, FUNC_DISABLE, FUNC_TEST: begin
                     if (!in_range) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.ret_value   = (f_new == FUNC_TEST) ? 32'd0 : 32'd1;
                        rsp_in.index_error = 1'b1;
                        rsp_in.last        = 1'b1;
                     end else begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = req_data.handle[SLOT_W-1:0];
                        state_in          = S_SINGLE;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                  end
               endcase
            end
         end

         S_SINGLE: begin
            store_req.waddr = req_ff.handle[SLOT_W-1:0];
            rsp_strobe_in   = 1'b1;
            rsp_in.last     = 1'b1;
            state_in        = S_IDLE;
            case (f_cur) inside
               FUNC_CLOSE: begin
                  store_req.we_state = 1'b1;
                  store_req.wstate   = ST_FREE;
                  rsp_in.ret_value   = 32'd1;
               end
               FUNC_ENABLE, FUNC_DISABLE: begin
                  store_req.we_state = rd.state != ST_FREE;
                  store_req.wstate   = (f_cur == FUNC_ENABLE) ? ST_ENABLED : ST_DISABLED;
                  rsp_in.ret_value   = 32'd1;
               end
               FUNC_TEST: begin
                  store_req.we_state = rd.state == ST_PENDING;
                  store_req.wstate   = ST_ENABLED;
                  rsp_in.ret_value   = (rd.state == ST_PENDING) ? 32'd1 : 32'd0;
               end
               default: begin
                  rsp_in.ret_value = 32'd0;
               end
            endcase
         end

         S_SCAN: begin
            // issue the next slot read while the previous one is evaluated
            if (rd_idx_ff < eff) begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = rd_idx_ff[SLOT_W-1:0];
               rd_idx_in         = rd_idx_ff + EFF_W'(1);
               pv_in             = 1'b1;
               pidx_in           = rd_idx_ff;
            end
            if (pv_ff) begin
               store_req.waddr = pidx_ff[SLOT_W-1:0];
               case (f_cur) inside
                  FUNC_OPEN: begin
                     if (rd.state == ST_FREE) begin
                        store_req.we_state = 1'b1;
                        store_req.we_rec   = 1'b1;
                        store_req.wstate   = ST_DISABLED;
                        store_req.wrec.event_class  = req_ff.event_class;
                        store_req.wrec.event_spec   = req_ff.event_spec;
                        store_req.wrec.event_mode   = req_ff.event_mode;
                        store_req.wrec.handler_addr = req_ff.handler_addr;
                        rsp_strobe_in    = 1'b1;
                        rsp_in.ret_value = OPEN_TAG | 32'(pidx_ff);
                        rsp_in.last      = 1'b1;
                        pv_in            = 1'b0;
                        state_in         = S_IDLE;
                     end else if (last_slot) begin
                        rsp_strobe_in    = 1'b1;
                        rsp_in.ret_value = ALL_ONES;
                        rsp_in.last      = 1'b1;
                        state_in         = S_IDLE;
                     end
                  end
                  FUNC_DELIVER: begin
                     if (rd.state == ST_ENABLED && match) begin
                        if (rd.rec.event_mode == MODE_NO_CALLBACK) begin
                           store_req.we_state = 1'b1;
                           store_req.wstate   = ST_PENDING;
                        end else if (rd.rec.event_mode == MODE_CALLBACK &&
                                     rd.rec.handler_addr != 32'd0) begin
                           // hold one callback back so the final one can carry last
                           if (cb_pend_ff) begin
                              rsp_strobe_in         = 1'b1;
                              rsp_in.callback_valid = 1'b1;
                              rsp_in.callback_addr  = cb_addr_ff;
                              rsp_in.callback_slot  = cb_slot_ff;
                           end
                           cb_pend_in = 1'b1;
                           cb_addr_in = rd.rec.handler_addr;
                           cb_slot_in = CB_SLOT_W'(pidx_ff);
                        end
                     end
                     if (last_slot) begin
                        state_in = S_FLUSH;
                     end
                  end
                  FUNC_UNDELIVER: begin
                     if (rd.state == ST_PENDING && match &&
                         rd.rec.event_mode == MODE_NO_CALLBACK) begin
                        store_req.we_state = 1'b1;
                        store_req.wstate   = ST_ENABLED;
                     end
                     if (last_slot) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.last   = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                     pv_in         = 1'b0;
                     state_in      = S_IDLE;
                  end
               endcase
            end
         end

         S_FLUSH: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.last           = 1'b1;
            rsp_in.callback_valid = cb_pend_ff;
            rsp_in.callback_addr  = cb_pend_ff ? cb_addr_ff : 32'd0;
            rsp_in.callback_slot  = cb_pend_ff ? cb_slot_ff : '0;
            cb_pend_in            = 1'b0;
            state_in              = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pv_ff         <= 1'b0;
         cb_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pv_ff         <= pv_in;
         cb_pend_ff    <= cb_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff     <= req_in;
      rd_idx_ff  <= rd_idx_in;
      pidx_ff    <= pidx_in;
      cb_addr_ff <= cb_addr_in;
      cb_slot_ff <= cb_slot_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/event_control_block_table_core.sv */
// Event control block table, top level. Uses ecbt_pkg, ecbt_store, ecbt_seq.
// Immediate answers (out-of-range handle, zero slots, unused code) come straight
//   from idle; close/enable/disable/test read the slot, then answer; open answers at
//   the first free or last slot, undeliver at the last slot, deliver via a flush state.
// Throughput: one request at a time; the scan reads one slot per cycle from the
//   slot store, and open/deliver/undeliver keep the block busy until their last result.
// Reset: synchronous; all slots read as free at once, slot_count returns to 16.
module event_control_block_table_core (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  ecbt_pkg::req_type           req_data,
   // response channel, each result valid for a single cycle, no backpressure
   output logic                        rsp_strobe,
   output ecbt_pkg::rsp_type           rsp_data,
   // slot_count register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ecbt_pkg::CNT_W-1:0]  csr_wdata
);
   import ecbt_pkg::*;

   logic [CNT_W-1:0] slot_count_ff;
   logic [EFF_W-1:0] eff;
   store_req_type    store_req;
   store_rsp_type    store_rsp;

   // Config is only written while idle; refusing it while busy keeps a scan
   // bound stable, except against a write accepted together with a new request.
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         slot_count_ff <= csr_wdata;
      end
   end

   // effective slot count clamps at the table depth
   assign eff = eff_count(slot_count_ff);

   ecbt_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

   ecbt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .eff        (eff),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .store_req  (store_req),
      .store_rsp  (store_rsp)
   );

   // an accepted request either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither answered nor in progress");

   // a non-final deliver result means more results still follow
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final result while sequencer idle");

   // a callback is only requested for a real handler
   a_callback_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.callback_valid) |-> (rsp_data.callback_addr != 32'd0))
      else $error("callback result with zero handler");

   // no result appears without a request in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result without a request");

endmodule
